### rtl/gse_pkg.sv
// gse_pkg: shared types and constants for the glyph scanline expander.
// No dependencies.
`default_nettype none

package gse_pkg;

  localparam int FONT_WIDTH_DEF  = 10;
  localparam int FONT_HEIGHT_DEF = 20;
  localparam int GLYPH_COUNT_DEF = 256;

  localparam int MAX_PIXELS = 20;
  localparam int PIX_W      = 8;
  localparam int LINE_W     = MAX_PIXELS * PIX_W;

  typedef enum logic {
    MODE_LOAD   = 1'b0,
    MODE_RENDER = 1'b1
  } mode_t;

  localparam logic [1:0] DH_TOP    = 2'd1;
  localparam logic [1:0] DH_BOTTOM = 2'd2;

  // control that travels with a word down the pipeline
  typedef struct packed {
    mode_t      mode;
    logic [7:0] fg;
    logic [7:0] bg;
    logic       dw;
    logic       hit;
  } stage_ctrl_t;

endpackage

`default_nettype wire

### rtl/glyph_scanline_expander.sv
// Glyph scanline expander: three-stage pipeline, address / font memory / pixel expand.
// A word is registered in stage 1, then in the memory stage, then in the output register; one word
// per cycle sustained while the output is not stalled, set by the single font memory address (addr1_r).
// A stalled output holds all stages; in_ready = !out_valid || out_ready.
// Reset clears the pipeline valid bits only; font memory is undefined until loaded.
// Depends on gse_pkg.
`default_nettype none

module glyph_scanline_expander
  import gse_pkg::*;
#(
  parameter int FONT_WIDTH  = FONT_WIDTH_DEF,
  parameter int FONT_HEIGHT = FONT_HEIGHT_DEF,
  parameter int GLYPH_COUNT = GLYPH_COUNT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_mode,
  input  wire logic [7:0]  in_char_code,
  input  wire logic [4:0]  in_scan_line,
  input  wire logic [9:0]  in_font_bits,
  input  wire logic [7:0]  in_foreground,
  input  wire logic [7:0]  in_background,
  input  wire logic        in_reverse,
  input  wire logic        in_double_width,
  input  wire logic [1:0]  in_double_height,

  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      out_pixels_low,
  output logic [63:0]      out_pixels_mid,
  output logic [31:0]      out_pixels_high,
  output logic [4:0]       out_pixel_count
);

  localparam int DEPTH  = GLYPH_COUNT * FONT_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);

  logic advance;
  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;

  // ---------------- stage 1: address ----------------
  logic                  v1_r;
  stage_ctrl_t           c1_r, c1_nxt;
  logic [ADDR_W-1:0]     addr1_r, addr1_nxt;
  logic [FONT_WIDTH-1:0] wdata1_r;

  logic [5:0] font_row;
  logic [5:0] sel_row;
  logic       code_ok;
  logic       line_ok;
  logic       row_ok;

  always_comb begin
    font_row = {1'b0, in_scan_line};
    if (in_double_width && in_double_height == DH_TOP) begin
      font_row = {2'b00, in_scan_line[4:1]};
    end else if (in_double_width && in_double_height == DH_BOTTOM) begin
      font_row = 6'(FONT_HEIGHT / 2) + {2'b00, in_scan_line[4:1]};
    end

    code_ok = {1'b0, in_char_code} < 9'(GLYPH_COUNT);
    line_ok = {1'b0, in_scan_line} < 6'(FONT_HEIGHT);
    row_ok  = font_row < 6'(FONT_HEIGHT);

    sel_row = (in_mode == MODE_LOAD) ? {1'b0, in_scan_line} : font_row;

    c1_nxt.mode = mode_t'(in_mode);
    c1_nxt.fg   = in_reverse ? in_background : in_foreground;
    c1_nxt.bg   = in_reverse ? in_foreground : in_background;
    c1_nxt.dw   = in_double_width;
    c1_nxt.hit  = code_ok && line_ok && ((in_mode == MODE_LOAD) || row_ok);

    addr1_nxt = ADDR_W'(int'(in_char_code) * FONT_HEIGHT + int'(sel_row));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (advance) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      c1_r     <= c1_nxt;
      addr1_r  <= addr1_nxt;
      wdata1_r <= in_font_bits[FONT_WIDTH-1:0];
    end
  end

  // ---------------- stage 2: font memory ----------------
  logic [FONT_WIDTH-1:0] font_mem [DEPTH];
  logic                  v2_r;
  stage_ctrl_t           c2_r;
  logic [FONT_WIDTH-1:0] rdata_r;
  logic                  mem_we;

  assign mem_we = advance && v1_r && (c1_r.mode == MODE_LOAD) && c1_r.hit;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      font_mem[addr1_r] <= wdata1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rdata_r <= font_mem[addr1_r];
      c2_r    <= c1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (advance) begin
      v2_r <= v1_r;
    end
  end

  // ---------------- stage 3: pixel expand ----------------
  logic              out_valid_r;
  logic [LINE_W-1:0] pix_r, pix_nxt;
  logic [4:0]        cnt_r, cnt_nxt;
  logic [FONT_WIDTH-1:0] row;
  logic [7:0]        colour;

  always_comb begin
    row     = c2_r.hit ? rdata_r : '0;
    pix_nxt = '0;
    colour  = c2_r.bg;
    for (int x = 0; x < FONT_WIDTH; x++) begin
      colour = row[x] ? c2_r.fg : c2_r.bg;
      if (c2_r.dw) begin
        pix_nxt[(2*x)*PIX_W +: PIX_W]   = colour;
        pix_nxt[(2*x+1)*PIX_W +: PIX_W] = colour;
      end else begin
        pix_nxt[x*PIX_W +: PIX_W] = colour;
      end
    end
    cnt_nxt = c2_r.dw ? 5'(2 * FONT_WIDTH) : 5'(FONT_WIDTH);
    if (c2_r.mode == MODE_LOAD) begin
      pix_nxt = '0;
      cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pix_r <= pix_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixels_low  = pix_r[63:0];
  assign out_pixels_mid  = pix_r[127:64];
  assign out_pixels_high = pix_r[159:128];
  assign out_pixel_count = cnt_r;

`ifndef SYNTHESIS
  // a word in the memory stage reaches the output register on the next advance
  a_v2_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && v2_r) |=> out_valid_r)
    else $error("memory stage word lost");

  // a load leaves an empty line behind it
  a_load_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && v2_r && c2_r.mode == MODE_LOAD) |=>
      (out_pixel_count == 5'd0 && pix_r == '0))
    else $error("load word produced pixels");

  // count is one of the three legal widths
  a_count_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (cnt_r == 5'd0 || cnt_r == 5'(FONT_WIDTH)
                     || cnt_r == 5'(2 * FONT_WIDTH)))
    else $error("illegal pixel count");

  // memory written only by an in-range load moving out of stage 1
  a_we_load: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (v1_r && c1_r.mode == MODE_LOAD && advance))
    else $error("unexpected font memory write");
`endif

endmodule

`default_nettype wire

### tb/sv/glyph_scanline_expander_tb.sv
// Self-checking testbench for glyph_scanline_expander: font row loads and scanline
// renders with random gaps and output stalls, checked against an internal predictor.
// Depends on gse_pkg and the glyph_scanline_expander RTL.
`default_nettype none

module glyph_scanline_expander_tb;
  import gse_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD  = 12;
  localparam int FW          = FONT_WIDTH_DEF;
  localparam int FH          = FONT_HEIGHT_DEF;
  localparam int GLYPHS      = GLYPH_COUNT_DEF;
  localparam int STORE_DEPTH = GLYPHS * FH;
  localparam int N_RANDOM    = 1300;
  localparam int STALL_LIMIT = 4000;
  localparam int TAIL_CYCLES = 8;

  // double height codes without a package name: off, and the unused code
  localparam logic [1:0] DH_OFF    = 2'd0;
  localparam logic [1:0] DH_UNUSED = 2'd3;

  typedef struct {
    logic [63:0] low;
    logic [63:0] mid;
    logic [31:0] high;
    logic [4:0]  count;
  } scanline_t;

  class scanline_scoreboard;
    logic [FW-1:0] glyph_rows [STORE_DEPTH];
    scanline_t     pending_lines [$];
    int errors, loads, renders, wide, halves, blanks, checked;

    function new();
      errors = 0; loads = 0; renders = 0; wide = 0; halves = 0; blanks = 0; checked = 0;
    endfunction

    function int pending();
      return pending_lines.size();
    endfunction

    task report(string msg);
      errors++;
      $display("%0t ns  mismatch: %s", $realtime, msg);
    endtask

    // predict the word this input produces and queue it
    function void note_input(mode_t mode, logic [7:0] code, logic [4:0] line,
                             logic [9:0] font, logic [7:0] fg, logic [7:0] bg,
                             logic rev, logic dw, logic [1:0] dh);
      scanline_t        want;
      logic [LINE_W-1:0] pix;
      logic [7:0]       lit, unlit, c;
      logic [FW-1:0]    pattern;
      bit               in_range;
      int               font_row, n;
      in_range = (int'(code) < GLYPHS) && (int'(line) < FH);
      pix = '0;
      n = 0;
      if (mode == MODE_LOAD) begin
        loads++;
        if (in_range)
          glyph_rows[int'(code) * FH + int'(line)] = font[FW-1:0];
      end else begin
        renders++;
        lit   = rev ? bg : fg;
        unlit = rev ? fg : bg;
        font_row = int'(line);
        if (dw && dh == DH_TOP)
          font_row = int'(line) >> 1;
        else if (dw && dh == DH_BOTTOM)
          font_row = FH / 2 + (int'(line) >> 1);
        if (dw) wide++;
        if (dw && (dh == DH_TOP || dh == DH_BOTTOM)) halves++;
        if (!in_range) blanks++;
        pattern = '0;
        if (in_range && font_row < FH)
          pattern = glyph_rows[int'(code) * FH + font_row];
        for (int x = 0; x < FW; x++) begin
          c = pattern[x] ? lit : unlit;
          for (int k = 0; k < (dw ? 2 : 1); k++) begin
            pix[n * PIX_W +: PIX_W] = c;
            n++;
          end
        end
      end
      want.low   = pix[63:0];
      want.mid   = pix[127:64];
      want.high  = pix[159:128];
      want.count = n[4:0];
      pending_lines.push_back(want);
    endfunction

    task check_line(logic [63:0] low, logic [63:0] mid, logic [31:0] high,
                    logic [4:0] count);
      scanline_t want;
      if (pending_lines.size() == 0) begin
        report("scanline word with nothing pending");
        return;
      end
      want = pending_lines.pop_front();
      checked++;
      if (low !== want.low)
        report($sformatf("pixels_low %h, predicted %h", low, want.low));
      if (mid !== want.mid)
        report($sformatf("pixels_mid %h, predicted %h", mid, want.mid));
      if (high !== want.high)
        report($sformatf("pixels_high %h, predicted %h", high, want.high));
      if (count !== want.count)
        report($sformatf("pixel_count %0d, predicted %0d", count, want.count));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_mode = 1'b0;
  logic [7:0]  in_char_code = '0;
  logic [4:0]  in_scan_line = '0;
  logic [9:0]  in_font_bits = '0;
  logic [7:0]  in_foreground = '0;
  logic [7:0]  in_background = '0;
  logic        in_reverse = 1'b0;
  logic        in_double_width = 1'b0;
  logic [1:0]  in_double_height = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] out_pixels_low;
  logic [63:0] out_pixels_mid;
  logic [31:0] out_pixels_high;
  logic [4:0]  out_pixel_count;

  scanline_scoreboard sb = new();
  bit  steady = 1'b0;
  bit  row_loaded [STORE_DEPTH];
  int  loaded_rows [$];
  int  quiet_cycles = 0;

  glyph_scanline_expander dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_char_code     (in_char_code),
    .in_scan_line     (in_scan_line),
    .in_font_bits     (in_font_bits),
    .in_foreground    (in_foreground),
    .in_background    (in_background),
    .in_reverse       (in_reverse),
    .in_double_width  (in_double_width),
    .in_double_height (in_double_height),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pixels_low   (out_pixels_low),
    .out_pixels_mid   (out_pixels_mid),
    .out_pixels_high  (out_pixels_high),
    .out_pixel_count  (out_pixel_count)
  );

  always #(CLK_PERIOD / 2.0) clk = ~clk;

  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 14);
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      sb.note_input(mode_t'(in_mode), in_char_code, in_scan_line, in_font_bits,
                    in_foreground, in_background, in_reverse, in_double_width,
                    in_double_height);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_line(out_pixels_low, out_pixels_mid, out_pixels_high, out_pixel_count);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t ns  no word moved for %0d cycles, %0d still pending",
                 $realtime, STALL_LIMIT, sb.pending());
        $display("glyph_scanline_expander_tb: done, errors");
        $finish;
      end
    end
  end

  task automatic send_word(mode_t mode, logic [7:0] code, logic [4:0] line,
                           logic [9:0] font, logic [7:0] fg, logic [7:0] bg,
                           logic rev, logic dw, logic [1:0] dh);
    while (!steady && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_mode          <= mode;
    in_char_code     <= code;
    in_scan_line     <= line;
    in_font_bits     <= font;
    in_foreground    <= fg;
    in_background    <= bg;
    in_reverse       <= rev;
    in_double_width  <= dw;
    in_double_height <= dh;
    in_valid         <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic load_row(logic [7:0] code, logic [4:0] line, logic [9:0] font);
    int idx;
    idx = int'(code) * FH + int'(line);
    if (int'(line) < FH && !row_loaded[idx]) begin
      row_loaded[idx] = 1'b1;
      loaded_rows.push_back(idx);
    end
    send_word(MODE_LOAD, code, line, font, 8'($urandom_range(255)),
              8'($urandom_range(255)), 1'($urandom_range(1)), 1'($urandom_range(1)),
              2'($urandom_range(3)));
  endtask

  task automatic render(logic [7:0] code, logic [4:0] line, logic [7:0] fg,
                        logic [7:0] bg, logic rev, logic dw, logic [1:0] dh);
    send_word(MODE_RENDER, code, line, 10'($urandom_range(1023)), fg, bg, rev, dw, dh);
  endtask

  // hold the sender until every predicted word has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int          pick, idx, fr;
    logic [7:0]  code;
    logic [4:0]  line;
    logic        dw;
    logic [1:0]  dh;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, reverse, widths, half heights, ignored and blank rows
    load_row(8'd0,   5'd0,  10'h3FF);
    load_row(8'd0,   5'd10, 10'h000);
    load_row(8'd255, 5'd19, 10'h2AA);
    load_row(8'd255, 5'd9,  10'h155);
    load_row(8'd255, 5'd0,  10'h201);
    load_row(8'd7,   5'd20, 10'h3FF);
    load_row(8'd7,   5'd31, 10'h3FF);
    render(8'd0,   5'd0,  8'hFF, 8'h00, 1'b0, 1'b0, DH_OFF);
    render(8'd0,   5'd0,  8'hFF, 8'h00, 1'b1, 1'b0, DH_OFF);
    render(8'd0,   5'd0,  8'h5A, 8'hA5, 1'b0, 1'b1, DH_OFF);
    render(8'd0,   5'd1,  8'h12, 8'h34, 1'b0, 1'b1, DH_TOP);
    render(8'd0,   5'd0,  8'h12, 8'h34, 1'b0, 1'b1, DH_BOTTOM);
    render(8'd0,   5'd0,  8'h12, 8'h34, 1'b0, 1'b1, DH_UNUSED);
    render(8'd0,   5'd0,  8'h12, 8'h34, 1'b0, 1'b0, DH_TOP);
    render(8'd255, 5'd19, 8'h00, 8'hFF, 1'b0, 1'b0, DH_OFF);
    render(8'd255, 5'd19, 8'hC3, 8'h3C, 1'b0, 1'b1, DH_TOP);
    render(8'd255, 5'd18, 8'hC3, 8'h3C, 1'b1, 1'b1, DH_BOTTOM);
    render(8'd255, 5'd0,  8'hFF, 8'h01, 1'b1, 1'b1, DH_OFF);
    render(8'd7,   5'd20, 8'hEE, 8'h11, 1'b0, 1'b0, DH_OFF);
    render(8'd255, 5'd31, 8'hEE, 8'h11, 1'b1, 1'b1, DH_BOTTOM);
    load_row(8'd0, 5'd0, 10'h3E0);
    render(8'd0,   5'd0,  8'h80, 8'h7F, 1'b0, 1'b1, DH_OFF);
    wait_drained();

    for (int i = 0; i < N_RANDOM; i++) begin
      steady = (i >= 500 && i < 750);
      if (i == 300 || i == 900)
        wait_drained();
      pick = $urandom_range(99);
      if (pick < 30) begin
        code = 8'($urandom_range(GLYPHS - 1));
        line = 5'($urandom_range(FH - 1));
        if ($urandom_range(11) == 0) begin
          line = 5'($urandom_range(31, FH));
        end else if ($urandom_range(4) == 0) begin
          idx  = loaded_rows[$urandom_range(loaded_rows.size() - 1)];
          code = 8'(idx / FH);
          line = 5'(idx % FH);
        end
        load_row(code, line, 10'($urandom_range(1023)));
      end else if (pick < 90) begin
        idx  = loaded_rows[$urandom_range(loaded_rows.size() - 1)];
        code = 8'(idx / FH);
        fr   = idx % FH;
        if ($urandom_range(1)) begin
          dw   = 1'b1;
          dh   = (fr < FH / 2) ? DH_TOP : DH_BOTTOM;
          line = 5'(2 * (fr % (FH / 2)) + int'($urandom_range(1)));
        end else begin
          line = 5'(fr);
          dw   = 1'($urandom_range(1));
          dh   = 2'($urandom_range(3));
          if (dw && (dh == DH_TOP || dh == DH_BOTTOM))
            dh = $urandom_range(1) ? DH_UNUSED : DH_OFF;
        end
        render(code, line, 8'($urandom_range(255)), 8'($urandom_range(255)),
               1'($urandom_range(1)), dw, dh);
      end else begin
        render(8'($urandom_range(GLYPHS - 1)), 5'($urandom_range(31, FH)),
               8'($urandom_range(255)), 8'($urandom_range(255)), 1'($urandom_range(1)),
               1'($urandom_range(1)), 2'($urandom_range(3)));
      end
    end
    steady = 1'b0;

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("glyph_scanline_expander_tb: %0d font row loads, %0d renders", sb.loads,
             sb.renders);
    $display("  (%0d double width, %0d half height, %0d outside the font), %0d checked",
             sb.wide, sb.halves, sb.blanks, sb.checked);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("glyph_scanline_expander_tb: done, clean");
    else
      $display("glyph_scanline_expander_tb: done, errors");
    $finish;
  end

endmodule

`default_nettype wire
